// File: sv/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CEH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CEH_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define CEH_ASSERT(lbl, clk, rst_n, prop, msg)
`define CEH_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// File: sv/ceh_pkg.sv
// Package for the compressed event header decoder: field phases, codes, job type.
// No dependencies.
`default_nettype none
package ceh_pkg;
  localparam int unsigned NumSaved = 12;
  localparam int unsigned LastCode = 13;

  localparam logic [3:0] PH_FLAGS   = 4'd0;
  localparam logic [3:0] PH_META    = 4'd1;
  localparam logic [3:0] PH_SEQ     = 4'd2;
  localparam logic [3:0] PH_CAPT    = 4'd3;
  localparam logic [3:0] PH_CPU     = 4'd4;
  localparam logic [3:0] PH_THREAD  = 4'd5;
  localparam logic [3:0] PH_STACK   = 4'd6;
  localparam logic [3:0] PH_TIME    = 4'd7;
  localparam logic [3:0] PH_ACT     = 4'd8;
  localparam logic [3:0] PH_REL     = 4'd9;
  localparam logic [3:0] PH_PAYLOAD = 4'd10;

  localparam logic [3:0] CODE_SORTED = 4'd12;
  localparam logic [3:0] CODE_HDR    = 4'd13;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVF32 = 2'd1;
  localparam logic [1:0] ST_OVF64 = 2'd2;

  localparam logic [6:0] Lim32 = 7'd35;  // 5 groups of 7 bits
  localparam logic [6:0] Lim64 = 7'd70;  // 10 groups of 7 bits

  typedef logic [NumSaved-1:0][63:0] fields_t;

  typedef struct packed {
    logic       is_err;
    logic [3:0] code;
    logic [1:0] status;
    fields_t    fields;
    logic       sorted;
    logic [6:0] hdr;
  } job_t;
endpackage
`default_nettype wire

// File: sv/ceh_front.sv
// Front end: byte-wise header parser holding the inherited fields.
// Depends on ceh_pkg; emits one burst job per completed header, or one error job per overlong varint.
`default_nettype none
module ceh_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    header_byte_i,
  input  wire logic          block_start_i,
  output ceh_pkg::job_t      job_o,
  output logic               job_valid_o
);
  ceh_pkg::fields_t fields_q, fields_d;
  logic [3:0]  phase_q, phase_d;
  logic [7:0]  flags_q, flags_d;
  logic [63:0] acc_q, acc_d;
  logic [6:0]  shift_q, shift_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [6:0]  hdr_q, hdr_d;

  logic        adv, found, is64;
  logic [3:0]  from, nxt;
  logic [63:0] acc_new;
  logic [6:0]  shift_new;
  logic [3:0]  idx;
  logic [5:0]  bsh;
  logic [10:0] present;

  always_comb begin
    fields_d    = block_start_i && accept_i ? '0 : fields_q;
    phase_d     = phase_q;
    flags_d     = flags_q;
    acc_d       = acc_q;
    shift_d     = shift_q;
    cnt_d       = cnt_q;
    hdr_d       = hdr_q;
    adv         = 1'b0;
    from        = ceh_pkg::PH_FLAGS;
    job_valid_o = 1'b0;
    job_o       = '0;
    is64        = (phase_q == ceh_pkg::PH_CAPT) || (phase_q == ceh_pkg::PH_THREAD) ||
                  (phase_q == ceh_pkg::PH_TIME);
    acc_new     = shift_q[6] ? acc_q : (acc_q | ({57'd0, header_byte_i[6:0]} << shift_q[5:0]));
    if (!is64) acc_new[63:32] = '0;
    shift_new   = shift_q + 7'd7;
    idx         = (phase_q == ceh_pkg::PH_ACT) ? 4'd7 : 4'd9;
    idx         = idx + {3'd0, cnt_q[3]};
    bsh         = {cnt_q[2:0], 3'd0};
    if (accept_i) begin
      if (block_start_i || phase_q == ceh_pkg::PH_FLAGS) begin
        flags_d = header_byte_i;
        hdr_d   = 7'd1;
        adv     = 1'b1;
      end else begin
        if (hdr_q != 7'h7f) hdr_d = hdr_q + 7'd1;
        if (phase_q == ceh_pkg::PH_ACT || phase_q == ceh_pkg::PH_REL) begin
          fields_d[idx] = (fields_q[idx] & ~(64'hff << bsh)) |
                          ({56'd0, header_byte_i} << bsh);
          cnt_d = cnt_q + 4'd1;
          if (cnt_q == 4'hf) begin
            adv  = 1'b1;
            from = phase_q;
          end
        end else if (header_byte_i[7]) begin
          acc_d   = acc_new;
          shift_d = shift_new;
          if (shift_new >= (is64 ? ceh_pkg::Lim64 : ceh_pkg::Lim32)) begin
            // overlong varint: report and restart on a flags byte
            job_valid_o   = 1'b1;
            job_o.is_err  = 1'b1;
            job_o.code    = phase_q - 4'd1;
            job_o.status  = is64 ? ceh_pkg::ST_OVF64 : ceh_pkg::ST_OVF32;
            phase_d       = ceh_pkg::PH_FLAGS;
            acc_d         = '0;
            shift_d       = '0;
            cnt_d         = '0;
          end
        end else begin
          adv  = 1'b1;
          from = phase_q;
          unique case (phase_q)
            ceh_pkg::PH_META:   fields_d[0] = acc_new;
            ceh_pkg::PH_SEQ:    fields_d[1] = {32'd0, fields_q[1][31:0] + acc_new[31:0] + 32'd1};
            ceh_pkg::PH_CAPT:   fields_d[2] = acc_new;
            ceh_pkg::PH_CPU:    fields_d[3] = acc_new;
            ceh_pkg::PH_THREAD: fields_d[4] = acc_new;
            ceh_pkg::PH_STACK:  fields_d[5] = acc_new;
            ceh_pkg::PH_TIME:   fields_d[6] = fields_q[6] + acc_new;
            default:            fields_d[11] = acc_new;
          endcase
        end
      end
    end
    present = {flags_d[7], flags_d[5], flags_d[4], 1'b1, flags_d[3], flags_d[2],
               flags_d[1], flags_d[1], flags_d[1], flags_d[0], 1'b0};
    found = 1'b0;
    nxt   = ceh_pkg::PH_FLAGS;
    for (int p = 10; p >= 1; p--) begin
      if (4'(p) > from && present[p]) begin
        found = 1'b1;
        nxt   = 4'(p);
      end
    end
    if (adv) begin
      acc_d   = '0;
      shift_d = '0;
      cnt_d   = '0;
      // no sequence delta: bump the sequence when the metadata id is nonzero
      if ((from == ceh_pkg::PH_META || (from == ceh_pkg::PH_FLAGS && !flags_d[0])) &&
          !flags_d[1] && fields_d[0] != 64'd0)
        fields_d[1] = {32'd0, fields_d[1][31:0] + 32'd1};
      phase_d = nxt;
      if (!found) begin
        job_valid_o  = 1'b1;
        job_o.fields = fields_d;
        job_o.sorted = flags_d[6];
        job_o.hdr    = hdr_d;
        job_o.status = ceh_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fields_q <= '0;
      phase_q  <= ceh_pkg::PH_FLAGS;
      flags_q  <= '0;
      acc_q    <= '0;
      shift_q  <= '0;
      cnt_q    <= '0;
      hdr_q    <= '0;
    end else begin
      fields_q <= fields_d;
      phase_q  <= phase_d;
      flags_q  <= flags_d;
      acc_q    <= acc_d;
      shift_q  <= shift_d;
      cnt_q    <= cnt_d;
      hdr_q    <= hdr_d;
    end
  end
endmodule
`default_nettype wire

// File: sv/ceh_queue.sv
// Two-entry job queue between the parser and the result serializer.
// Depends on ceh_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module ceh_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  ceh_pkg::job_t      job_i,
  output logic               full_o,
  output logic               valid_o,
  output ceh_pkg::job_t      job_o,
  input  wire logic          deq_i
);
  ceh_pkg::job_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (deq_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, deq_i};
    end
  end

  `CEH_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q != 2'd3, "queue count out of range")
  `CEH_ASSERT(a_no_overflow, clk_i, rst_ni, !(push_i && full_o), "push into full queue")
  `CEH_ASSERT(a_no_underflow, clk_i, rst_ni, !(deq_i && !valid_o), "dequeue from empty queue")
endmodule
`default_nettype wire

// File: sv/ceh_back.sv
// Back end: expands each job into its result sequence behind an output register.
// Depends on ceh_pkg.
`default_nettype none
module ceh_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  ceh_pkg::job_t      job_i,
  output logic               deq_o,
  input  wire logic          pop,
  output logic               empty,
  output logic [3:0]         field_code_o,
  output logic [63:0]        field_value_o,
  output logic [1:0]         status_o,
  output logic               last_o
);
  logic        out_valid_q;
  logic [3:0]  idx_q;
  logic        load;
  logic [63:0] val;

  assign empty = !out_valid_q;
  assign load  = valid_i && (!out_valid_q || pop);
  assign deq_o = load && (job_i.is_err || idx_q == ceh_pkg::CODE_HDR);

  always_comb begin
    if (idx_q == ceh_pkg::CODE_HDR)         val = {57'd0, job_i.hdr};
    else if (idx_q == ceh_pkg::CODE_SORTED) val = {63'd0, job_i.sorted};
    else                                    val = job_i.fields[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      field_code_o  <= job_i.is_err ? job_i.code : idx_q;
      field_value_o <= job_i.is_err ? 64'd0 : val;
      status_o      <= job_i.status;
      last_o        <= job_i.is_err || idx_q == ceh_pkg::CODE_HDR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) out_valid_q <= 1'b1;
      else if (pop) out_valid_q <= 1'b0;
      if (deq_o) idx_q <= '0;
      else if (load) idx_q <= idx_q + 4'd1;
    end
  end
endmodule
`default_nettype wire

// File: sv/compressed_event_header_decoder_core.sv
// Compressed event header decoder, top level.
// Depends on ceh_pkg, ceh_front, ceh_queue, ceh_back.
//
// Input channel: one header byte per transaction (push/full). block_start_i
// clears the inherited fields and marks the byte as a new flags byte.
// The parser takes one byte per cycle while the job queue has room.
// Result channel (empty/pop): when the last byte of a header is taken, a
// burst of 14 transactions follows, field codes 0..13 in order, the last
// flagged by last_o. An overlong varint gives a single error transaction.
// The first result of a burst passes through the job queue and then the
// output register. The serializer hands out one result per cycle while the
// receiver pops; the two-entry job queue absorbs the difference between the
// byte and result rates, and full rises when it fills.
// If the receiver stalls, the output register holds its result, the queue
// fills and then full holds off the byte stream; nothing is dropped.
// Reset clears the inherited fields and waits for a flags byte.
`default_nettype none
module compressed_event_header_decoder_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  header_byte_i,
  input  wire logic        block_start_i,
  input  wire logic        pop,
  output logic             empty,
  output logic [3:0]       field_code_o,
  output logic [63:0]      field_value_o,
  output logic [1:0]       status_o,
  output logic             last_o
);
  ceh_pkg::job_t job_in, job_head;
  logic job_push, head_valid, head_deq, accept;

  // take a byte only while a job slot is free
  assign accept = push && !full;

  ceh_front u_front (
    .clk_i, .rst_ni,
    .accept_i(accept), .header_byte_i, .block_start_i,
    .job_o(job_in), .job_valid_o(job_push)
  );

  ceh_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(job_push), .job_i(job_in), .full_o(full),
    .valid_o(head_valid), .job_o(job_head), .deq_i(head_deq)
  );

  ceh_back u_back (
    .clk_i, .rst_ni,
    .valid_i(head_valid), .job_i(job_head), .deq_o(head_deq),
    .pop, .empty, .field_code_o, .field_value_o, .status_o, .last_o
  );
endmodule
`default_nettype wire

// File: tb/ceh_checker.sv
// Result checker for the compressed event header decoder: tracks accepted
// header bytes, predicts the field bursts and compares each popped result.
// Depends on ceh_pkg.
module ceh_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  header_byte_i,
  input  logic        block_start_i,
  input  logic        pop,
  input  logic        empty,
  input  logic [3:0]  field_code_o,
  input  logic [63:0] field_value_o,
  input  logic [1:0]  status_o,
  input  logic        last_o,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]  code;
    logic [63:0] value;
    logic [1:0]  status;
    logic        last;
  } field_rec_t;

  field_rec_t expected_fields[$];
  logic [63:0] inherited[ceh_pkg::NumSaved];
  logic [3:0]  cur_phase;
  logic [7:0]  hdr_flags;
  logic [63:0] acc;
  int unsigned acc_shift;
  int unsigned id_count;
  int unsigned hdr_len;
  int          fails;

  assign fail_count_o = fails;
  assign pending_o = expected_fields.size();

  function automatic bit present(logic [3:0] p);
    case (p) inside
      ceh_pkg::PH_META:    return hdr_flags[0];
      ceh_pkg::PH_SEQ, ceh_pkg::PH_CAPT, ceh_pkg::PH_CPU: return hdr_flags[1];
      ceh_pkg::PH_THREAD:  return hdr_flags[2];
      ceh_pkg::PH_STACK:   return hdr_flags[3];
      ceh_pkg::PH_TIME:    return 1'b1;
      ceh_pkg::PH_ACT:     return hdr_flags[4];
      ceh_pkg::PH_REL:     return hdr_flags[5];
      ceh_pkg::PH_PAYLOAD: return hdr_flags[7];
      default:             return 1'b0;
    endcase
  endfunction

  function automatic field_rec_t mk(logic [3:0] c, logic [63:0] v, logic [1:0] s, logic l);
    field_rec_t r;
    r.code = c; r.value = v; r.status = s; r.last = l;
    return r;
  endfunction

  task automatic expect_rec(field_rec_t r);
    expected_fields.insert(expected_fields.size(), r);
  endtask

  // Move to the next present field; queue the burst once the header is done.
  task automatic next_field(logic [3:0] from);
    int p;
    p = from + 1;
    acc = '0; acc_shift = 0; id_count = 0;
    while (p <= ceh_pkg::PH_PAYLOAD) begin
      if (p == ceh_pkg::PH_SEQ && !present(ceh_pkg::PH_SEQ)) begin
        if (inherited[0] != 0) inherited[1] = (inherited[1] + 1) & 64'hFFFF_FFFF;
        p = ceh_pkg::PH_THREAD;
        continue;
      end
      if (present(4'(p))) begin
        cur_phase = 4'(p);
        return;
      end
      p++;
    end
    cur_phase = ceh_pkg::PH_FLAGS;
    for (int k = 0; k < ceh_pkg::NumSaved; k++)
      expect_rec(mk(4'(k), inherited[k], ceh_pkg::ST_OK, 1'b0));
    expect_rec(mk(ceh_pkg::CODE_SORTED, {63'd0, hdr_flags[6]}, ceh_pkg::ST_OK, 1'b0));
    expect_rec(mk(ceh_pkg::CODE_HDR, 64'(hdr_len), ceh_pkg::ST_OK, 1'b1));
  endtask

  task automatic take_byte(logic [7:0] b, logic bs);
    bit wide;
    int idx;
    if (bs) foreach (inherited[k]) inherited[k] = '0;
    if (bs || cur_phase == ceh_pkg::PH_FLAGS || cur_phase > ceh_pkg::PH_PAYLOAD) begin
      hdr_flags = b;
      hdr_len = 1;
      next_field(ceh_pkg::PH_FLAGS);
      return;
    end
    if (hdr_len < 127) hdr_len++;
    if (cur_phase == ceh_pkg::PH_ACT || cur_phase == ceh_pkg::PH_REL) begin
      idx = 7 + 2 * (cur_phase - ceh_pkg::PH_ACT) + (id_count / 8);
      inherited[idx][(id_count % 8) * 8 +: 8] = b;
      id_count++;
      if (id_count == 16) next_field(cur_phase);
      return;
    end
    wide = (cur_phase == ceh_pkg::PH_CAPT || cur_phase == ceh_pkg::PH_THREAD ||
            cur_phase == ceh_pkg::PH_TIME);
    if (acc_shift < 64) acc |= {57'd0, b[6:0]} << acc_shift;
    if (!wide) acc &= 64'hFFFF_FFFF;
    acc_shift += 7;
    if (b[7]) begin
      if (acc_shift >= (wide ? 70 : 35)) begin
        // Overlong varint: drop the partial field and expect a flags byte.
        expect_rec(mk(4'(cur_phase - 4'd1), '0,
                      wide ? ceh_pkg::ST_OVF64 : ceh_pkg::ST_OVF32, 1'b1));
        cur_phase = ceh_pkg::PH_FLAGS;
        acc = '0; acc_shift = 0; id_count = 0;
      end
      return;
    end
    case (cur_phase)
      ceh_pkg::PH_META:   inherited[0] = acc;
      ceh_pkg::PH_SEQ:    inherited[1] = (inherited[1] + acc + 1) & 64'hFFFF_FFFF;
      ceh_pkg::PH_CAPT:   inherited[2] = acc;
      ceh_pkg::PH_CPU:    inherited[3] = acc;
      ceh_pkg::PH_THREAD: inherited[4] = acc;
      ceh_pkg::PH_STACK:  inherited[5] = acc;
      ceh_pkg::PH_TIME:   inherited[6] = inherited[6] + acc;
      default:            inherited[11] = acc;
    endcase
    next_field(cur_phase);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    field_rec_t e;
    if (!rst_ni) begin
      foreach (inherited[k]) inherited[k] = '0;
      cur_phase = ceh_pkg::PH_FLAGS; hdr_flags = '0; acc = '0;
      acc_shift = 0; id_count = 0; hdr_len = 0; fails = 0;
      expected_fields.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_fields.size() == 0) begin
          $error("unexpected result code %0d value %0h", field_code_o, field_value_o);
          fails++;
        end else begin
          e = expected_fields.pop_front();
          if (field_code_o !== e.code) begin
            $error("field_code exp %0d got %0d", e.code, field_code_o); fails++;
          end
          if (field_value_o !== e.value) begin
            $error("field_value exp %0h got %0h", e.value, field_value_o); fails++;
          end
          if (status_o !== e.status) begin
            $error("status exp %0d got %0d", e.status, status_o); fails++;
          end
          if (last_o !== e.last) begin
            $error("last exp %0d got %0d", e.last, last_o); fails++;
          end
        end
      end
      if (push && !full) take_byte(header_byte_i, block_start_i);
    end
  end
endmodule

// File: tb/tb.sv
// Testbench top for the compressed event header decoder: drives header byte
// streams with random gaps and stalls, and reports the verdict.
// Depends on ceh_pkg, ceh_checker and compressed_event_header_decoder_core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        push = 0;
  logic        full;
  logic [7:0]  header_byte_i = '0;
  logic        block_start_i = 0;
  logic        pop = 0;
  logic        empty;
  logic [3:0]  field_code_o;
  logic [63:0] field_value_o;
  logic [1:0]  status_o;
  logic        last_o;
  int          fail_count;
  int          pending;
  bit          no_gaps = 0;   // set during the stretch without idling

  // Bytes waiting to be sent: {block_start, byte}.
  logic [8:0] byte_stream[$];
  int         items_sent = 0;

  compressed_event_header_decoder_core DUT (.*);

  ceh_checker checker_i (.*, .fail_count_o(fail_count), .pending_o(pending));

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: pop about two thirds of the cycles, always during the fast stretch.
  always @(posedge clk_i) begin
    pop <= no_gaps || ($urandom_range(99) >= 34);
  end

  task automatic add_byte(logic [8:0] x);
    byte_stream.insert(byte_stream.size(), x);
  endtask

  // Append an LEB128 varint; groups sets the byte count so padded forms appear.
  task automatic add_varint(logic [63:0] v, int groups);
    for (int g = 0; g < groups; g++) begin
      add_byte({1'b0, (g < groups - 1), v[6:0]});
      v = v >> 7;
    end
  endtask

  function automatic int groups_for(logic [63:0] v);
    int n;
    n = 1;
    while ((v >> (7 * n)) != 0 && n < 10) n++;
    return n;
  endfunction

  function automatic logic [63:0] rand_val(bit wide);
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(3))
      0: v = v & 64'h7F;
      1: v = v & 64'h3FFF;
      default: ;
    endcase
    return wide ? v : (v & 64'hFFFF_FFFF);
  endfunction

  // Build one header; fields follow the flags in fixed order.
  task automatic add_header(logic [7:0] flags, bit bs, bit overlong);
    int bad;
    bad = overlong ? $urandom_range(5) : -1;
    add_byte({bs, flags});
    for (int f = 0; f < 8; f++) begin
      bit wide, pres;
      logic [63:0] v;
      case (f)
        0: begin pres = flags[0]; wide = 0; end
        1: begin pres = flags[1]; wide = 0; end
        2: begin pres = flags[1]; wide = 1; end
        3: begin pres = flags[1]; wide = 0; end
        4: begin pres = flags[2]; wide = 1; end
        5: begin pres = flags[3]; wide = 0; end
        6: begin pres = 1; wide = 1; end
        default: begin pres = flags[7]; wide = 0; end
      endcase
      if (f == 7) begin
        for (int k = 0; k < 16 * flags[4] + 16 * flags[5]; k++)
          add_byte({1'b0, 8'($urandom)});
      end
      if (!pres) continue;
      v = rand_val(wide);
      if (bad == f || (bad >= 0 && f == 6)) begin
        // Overlong: continuation still set on the last allowed group.
        for (int g = 0; g < (wide ? 10 : 5); g++)
          add_byte({1'b0, 1'b1, 7'(v >> (7 * g))});
        return;
      end
      // Sometimes pad with redundant groups up to the limit.
      add_varint(v, ($urandom_range(7) == 0) ? (wide ? 10 : 5) : groups_for(v));
    end
  endtask

  task automatic send_all();
    while (byte_stream.size() != 0) begin
      @(posedge clk_i);
      if (push && !full) begin
        items_sent++;
        void'(byte_stream.pop_front());
      end
      if (byte_stream.size() != 0 && (no_gaps || $urandom_range(99) >= 34)) begin
        push <= 1;
        {block_start_i, header_byte_i} <= byte_stream[0];
      end else begin
        push <= 0;
      end
    end
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    // Directed: empty and full flag sets, extremes, overlongs, block restart.
    add_header(8'h00, 1, 0);
    add_header(8'hFF, 0, 0);
    add_header(8'h01, 0, 0);
    add_header(8'h00, 0, 0);
    add_header(8'h0A, 0, 0);
    add_byte({1'b0, 8'h02});
    add_varint(64'hFFFF_FFFF, 5);
    add_varint(64'hFFFF_FFFF_FFFF_FFFF, 10);
    add_varint(64'hFFFF_FFFF, 5);
    add_varint(64'hFFFF_FFFF_FFFF_FFFF, 10);
    add_header(8'h01, 0, 1);
    add_header(8'h02, 0, 1);
    // Restart in the middle of a header.
    add_byte({1'b0, 8'h10});
    add_byte({1'b0, 8'h85});
    add_header(8'hC0, 1, 0);
    send_all();
    drain();   // sender holds off until every burst has come back
    while (items_sent < 420) begin
      logic [7:0] fl;
      fl = $urandom;
      no_gaps = (items_sent > 200 && items_sent < 260);
      case ($urandom_range(9))
        0: add_byte({1'($urandom), 8'($urandom)});   // noise
        1: add_header(fl, 0, 1);
        2: add_header(fl & 8'hCF, 1, 0);
        default: add_header(($urandom_range(3) == 0) ? fl : (fl & 8'hCF), 0, 0);
      endcase
      // Gather the whole stretch without idling and send it in one go.
      if (!no_gaps || byte_stream.size() >= 60) send_all();
    end
    no_gaps = 0;
    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
